[rtl/pru_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pru_pkg;

  // fixed field widths
  localparam int unsigned WIDTH_W    = 12;
  localparam int unsigned FACTOR_W   = 7;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned CFG_IDX_W  = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 1'd1;

  // input item kinds
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // result queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_PAD    = 2'd1,
    KIND_REJECT = 2'd2
  } item_kind_e;

  typedef struct packed {
    logic       replay_end;
    logic       row_end;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    item_kind_e kind;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t item;
  } queue_wr_t;

endpackage

`default_nettype wire

[rtl/pru_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module pru_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/pru_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module pru_front #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_FACTOR = 100
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          in_func_i,
  input  wire logic [7:0]                    in_blue_i,
  input  wire logic [7:0]                    in_green_i,
  input  wire logic [7:0]                    in_red_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [pru_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [pru_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                          room_i,
  output pru_pkg::queue_wr_t                 wr_o
);

  import pru_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned FW = $clog2(MAX_FACTOR + 1);

  logic [WIDTH_W-1:0]  width_q;
  logic [FACTOR_W-1:0] factor_q;

  logic          replaying_q, replaying_d;
  logic          in_pad_q, in_pad_d;
  logic [CW-1:0] load_col_q, load_col_d;
  logic [CW-1:0] emit_col_q, emit_col_d;
  logic [FW-1:0] pix_rep_q, pix_rep_d;
  logic [FW-1:0] row_rep_q, row_rep_d;
  logic [1:0]    pad_cnt_q, pad_cnt_d;

  logic          s1_valid_q, s1_valid_d;
  result_t       s1_item_q, s1_item_d;

  logic [CW-1:0] eff_w;
  logic [FW-1:0] eff_f;
  logic [1:0]    w_lo, f_lo, len_lo, pad_bytes;
  logic          accept;
  logic          store_we;
  logic          do_finish;
  logic [CW-1:0] load_nxt, emit_nxt;
  logic [FW-1:0] pix_nxt, row_nxt;
  logic [2:0]    pad_nxt;
  logic [23:0]   rd_pixel;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_W'(1);
      factor_q <= FACTOR_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SOURCE_WIDTH: width_q  <= cfg_data_i[WIDTH_W-1:0];
        REG_SCALE_FACTOR: factor_q <= cfg_data_i[FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp live configuration to usable range
  always_comb begin
    if (width_q == '0) begin
      eff_w = CW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(width_q);
    end
    if (factor_q == '0) begin
      eff_f = FW'(1);
    end else if (32'(factor_q) > MAX_FACTOR) begin
      eff_f = FW'(MAX_FACTOR);
    end else begin
      eff_f = FW'(factor_q);
    end
  end

  // padding bytes needed to align 3 * width * factor to four
  assign w_lo      = 2'(eff_w);
  assign f_lo      = 2'(eff_f);
  assign len_lo    = 2'(w_lo * f_lo * 2'd3);
  assign pad_bytes = 2'(2'd0 - len_lo);

  assign in_ready_o = room_i;
  assign accept     = in_valid_i & room_i;

  assign load_nxt = load_col_q + CW'(1);
  assign emit_nxt = emit_col_q + CW'(1);
  assign pix_nxt  = pix_rep_q + FW'(1);
  assign row_nxt  = row_rep_q + FW'(1);
  assign pad_nxt  = {1'b0, pad_cnt_q} + 3'd1;

  // classify the request and step the load/replay counters
  always_comb begin
    replaying_d = replaying_q;
    in_pad_d    = in_pad_q;
    load_col_d  = load_col_q;
    emit_col_d  = emit_col_q;
    pix_rep_d   = pix_rep_q;
    row_rep_d   = row_rep_q;
    pad_cnt_d   = pad_cnt_q;
    store_we    = 1'b0;
    do_finish   = 1'b0;
    s1_valid_d  = 1'b0;
    s1_item_d   = '{replay_end: 1'b0, row_end: 1'b0, red: 8'd0, green: 8'd0,
                    blue: 8'd0, kind: KIND_PIXEL};

    if (accept) begin
      if (in_func_i == FUNC_PIXEL) begin
        if (replaying_q) begin
          // pixel during replay is echoed back as rejected
          s1_valid_d      = 1'b1;
          s1_item_d.kind  = KIND_REJECT;
          s1_item_d.blue  = in_blue_i;
          s1_item_d.green = in_green_i;
          s1_item_d.red   = in_red_i;
        end else begin
          store_we = 1'b1;
          if (load_nxt >= eff_w) begin
            load_col_d  = '0;
            replaying_d = 1'b1;
            emit_col_d  = '0;
            pix_rep_d   = '0;
            row_rep_d   = '0;
            pad_cnt_d   = '0;
            in_pad_d    = 1'b0;
          end else begin
            load_col_d = load_nxt;
          end
        end
      end else if (replaying_q) begin
        s1_valid_d = 1'b1;
        if (in_pad_q) begin
          s1_item_d.kind = KIND_PAD;
          if (pad_nxt >= {1'b0, pad_bytes}) begin
            do_finish = 1'b1;
          end else begin
            pad_cnt_d = pad_nxt[1:0];
          end
        end else begin
          s1_item_d.kind = KIND_PIXEL;
          if (pix_nxt >= eff_f) begin
            pix_rep_d = '0;
            if (emit_nxt >= eff_w) begin
              emit_col_d = '0;
              if (pad_bytes == 2'd0) begin
                do_finish = 1'b1;
              end else begin
                in_pad_d  = 1'b1;
                pad_cnt_d = '0;
              end
            end else begin
              emit_col_d = emit_nxt;
            end
          end else begin
            pix_rep_d = pix_nxt;
          end
        end
      end
    end

    // close one row copy, and the replay after the last copy
    if (do_finish) begin
      s1_item_d.row_end = 1'b1;
      emit_col_d = '0;
      pix_rep_d  = '0;
      pad_cnt_d  = '0;
      in_pad_d   = 1'b0;
      if (row_nxt >= eff_f) begin
        s1_item_d.replay_end = 1'b1;
        row_rep_d   = '0;
        replaying_d = 1'b0;
        load_col_d  = '0;
      end else begin
        row_rep_d = row_nxt;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      replaying_q <= 1'b0;
      in_pad_q    <= 1'b0;
      load_col_q  <= '0;
      emit_col_q  <= '0;
      pix_rep_q   <= '0;
      row_rep_q   <= '0;
      pad_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
    end else begin
      replaying_q <= replaying_d;
      in_pad_q    <= in_pad_d;
      load_col_q  <= load_col_d;
      emit_col_q  <= emit_col_d;
      pix_rep_q   <= pix_rep_d;
      row_rep_q   <= row_rep_d;
      pad_cnt_q   <= pad_cnt_d;
      s1_valid_q  <= s1_valid_d;
    end
  end

  // result payload is registered alongside the line store read
  always_ff @(posedge clk_i) begin
    s1_item_q <= s1_item_d;
  end

  // line store: written while loading, read at the replay column
  pru_ram #(
    .WIDTH (24),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (load_col_q[AW-1:0]),
    .wdata_i ({in_red_i, in_green_i, in_blue_i}),
    .raddr_i (emit_col_q[AW-1:0]),
    .rdata_o (rd_pixel)
  );

  // hand the finished result to the queue
  always_comb begin
    wr_o.push = s1_valid_q;
    wr_o.item = s1_item_q;
    if (s1_item_q.kind == KIND_PIXEL) begin
      wr_o.item.red   = rd_pixel[23:16];
      wr_o.item.green = rd_pixel[15:8];
      wr_o.item.blue  = rd_pixel[7:0];
    end
  end

endmodule

`default_nettype wire

[rtl/pru_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module pru_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pru_pkg::queue_wr_t wr_i,
  output logic                    room_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output pru_pkg::result_t        out_item_o
);

  import pru_pkg::*;

  result_t           q_mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  result_t           out_q;
  logic              pop;

  // room for the request in flight plus one more
  assign room_o = (cnt_q <= QCNT_W'(QDEPTH - 2));

  assign pop = (cnt_q != '0) && (!out_valid_q || out_ready_i);

  always_comb begin
    cnt_d = cnt_q;
    if (wr_i.push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (!wr_i.push && pop) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // queue pointers and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (wr_i.push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // queue storage and output register
  always_ff @(posedge clk_i) begin
    if (wr_i.push) begin
      q_mem_q[wr_ptr_q] <= wr_i.item;
    end
    if (pop) begin
      out_q <= q_mem_q[rd_ptr_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

[rtl/pixel_replicate_upscaler.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel  | direction | contents
// ---------+-----------+----------------------------------------------------
// s_axis   | in        | tuser: func; tdata: blue, green, red
// m_axis   | out       | tuser: item_kind, replay_end; tdata: blue, green,
//          |           | red; tlast: row_end
// cfg      | in        | index 0 source_width, index 1 scale_factor
//
// One request is taken every cycle while the result queue has room; a result
// passes through the line store read, the queue and the output register.
// All load and replay counters step in the front at acceptance; the back only
// drains the four-entry queue, so a stalled m_axis holds the front once the
// queue holds more than two entries. Reset clears all counters and returns to
// loading; the line store has no reset.

module pixel_replicate_upscaler #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_FACTOR = 100
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [23:0]                     s_axis_tdata,  // blue, green, red
  input  wire logic [0:0]                      s_axis_tuser,  // func
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic      [23:0]                     m_axis_tdata,  // blue, green, red
  output logic      [2:0]                      m_axis_tuser,  // item_kind, replay_end
  output logic                                 m_axis_tlast,  // row_end
  input  wire logic                            cfg_we_i,
  input  wire logic [pru_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [pru_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import pru_pkg::*;

  queue_wr_t q_wr;
  logic      q_room;
  result_t   out_item;

  // accept, classify and sequence requests
  pru_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_func_i  (s_axis_tuser[0]),
    .in_blue_i  (s_axis_tdata[7:0]),
    .in_green_i (s_axis_tdata[15:8]),
    .in_red_i   (s_axis_tdata[23:16]),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .room_i     (q_room),
    .wr_o       (q_wr)
  );

  // result queue and output register
  pru_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (q_wr),
    .room_o      (q_room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (out_item)
  );

  assign m_axis_tdata = {out_item.red, out_item.green, out_item.blue};
  assign m_axis_tuser = {out_item.replay_end, out_item.kind};
  assign m_axis_tlast = out_item.row_end;

endmodule

`default_nettype wire
